// ===== rtl/core/bresenham_circle_point_generator_unit_macros.svh =====
// Assertion macros shared by the circle generator RTL.
`ifndef BRESENHAM_CIRCLE_POINT_GENERATOR_UNIT_MACROS_SVH
`define BRESENHAM_CIRCLE_POINT_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bcpg_pkg.sv =====
`default_nettype none

package bcpg_pkg;

	localparam int COORD_W     = 10;
	localparam int RADIUS_W    = 6;
	localparam int POINT_W     = 12;
	localparam int STEP_X_W    = 7;
	localparam int STEP_Y_W    = 8;
	localparam int DEC_W       = 12;
	localparam int CNT_W       = 6;
	localparam int MAX_RESULTS = 46;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 8 * POINT_W;

	typedef logic signed [POINT_W-1:0] point_t;

endpackage

`default_nettype wire

// ===== rtl/core/bresenham_circle_point_generator_unit.sv =====
// Midpoint circle generator for the lower half of a circle. Each request on the slave side
// carries a centre and a radius of up to 63 pixels; the block then walks the decision variable
// once per clock cycle, stalling while the master side does not take a held result, and emits
// one result per step, holding the four mirrored points below the centre, with tlast on the
// final result of the circle. The starting point is not emitted, and a radius of zero yields a
// single result. A circle of radius r gives about 0.71 * r + 1 results (at most 46). The walk
// is set by the single decision update adder, which advances it by one step per cycle when the
// output is not stalled. A new request is accepted only once the last result of the previous
// one has been loaded into the output register.
`default_nettype none

`include "bresenham_circle_point_generator_unit_macros.svh"

module bresenham_circle_point_generator_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// Fields from bit 0: center_x, center_y, radius, zero padding.
	input  wire logic [bcpg_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// Fields from bit 0: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y.
	output logic [bcpg_pkg::OUT_TDATA_W-1:0]        m_tdata,
	output logic                                    m_tlast
);
	import bcpg_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                       state_q;
	logic [COORD_W-1:0]           cx_q;
	logic [COORD_W-1:0]           cy_q;
	logic [STEP_X_W-1:0]          x_q;
	logic signed [STEP_Y_W-1:0]   y_q;
	logic signed [DEC_W-1:0]      d_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         m_tvalid_q;
	logic                         m_tlast_q;
	logic [OUT_TDATA_W-1:0]       m_tdata_q;

	logic                         req_acc;
	logic                         adv;
	logic signed [DEC_W-1:0]      x_ext;
	logic signed [DEC_W-1:0]      y_ext;
	logic signed [DEC_W-1:0]      term;
	logic signed [DEC_W-1:0]      d_nx;
	logic [STEP_X_W-1:0]          x_nx;
	logic signed [STEP_Y_W-1:0]   y_nx;
	logic [CNT_W-1:0]             cnt_nx;
	logic                         last_nx;
	logic [RADIUS_W-1:0]          rad_in;
	point_t                       ox;
	point_t                       oy;
	point_t                       xe;
	point_t                       ye;
	logic [OUT_TDATA_W-1:0]       pts_nx;

	assign s_tready = (state_q == ST_IDLE);
	assign req_acc  = s_tvalid && s_tready;
	assign adv      = (state_q == ST_RUN) && (!m_tvalid_q || m_tready);
	assign rad_in   = s_tdata[2*COORD_W +: RADIUS_W];

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = m_tdata_q;

	// The decision update is the one shared adder that advances the walk by one step.
	always_comb begin
		x_ext = signed'(DEC_W'(x_q));
		y_ext = DEC_W'(y_q);
		if (d_q[DEC_W-1]) begin
			term = (x_ext <<< 2) + DEC_W'(6);
			y_nx = y_q;
		end else begin
			term = ((x_ext - y_ext) <<< 2) + DEC_W'(10);
			y_nx = y_q - STEP_Y_W'(1);
		end
		d_nx    = d_q + term;
		x_nx    = x_q + STEP_X_W'(1);
		cnt_nx  = cnt_q + CNT_W'(1);
		last_nx = (signed'({1'b0, x_nx}) > y_nx) || (cnt_nx == CNT_W'(MAX_RESULTS));
		ox      = signed'(POINT_W'(cx_q));
		oy      = signed'(POINT_W'(cy_q));
		xe      = signed'(POINT_W'(x_nx));
		ye      = POINT_W'(y_nx);
		pts_nx  = {oy - ye, ox + xe, oy - xe, ox + ye, oy - xe, ox - ye, oy - ye, ox - xe};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cx_q       <= '0;
			cy_q       <= '0;
			x_q        <= '0;
			y_q        <= '0;
			d_q        <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !adv) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						cx_q    <= s_tdata[0 +: COORD_W];
						cy_q    <= s_tdata[COORD_W +: COORD_W];
						x_q     <= '0;
						y_q     <= signed'(STEP_Y_W'(rad_in));
						d_q     <= DEC_W'(3) - signed'(DEC_W'({rad_in, 1'b0}));
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						x_q        <= x_nx;
						y_q        <= y_nx;
						d_q        <= d_nx;
						cnt_q      <= cnt_nx;
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= last_nx;
						m_tdata_q  <= pts_nx;
						if (last_nx) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BCPG_ASSERT_NEXT(a_load_starts_walk, clk, arst_n, req_acc,
		(state_q == ST_RUN) && (cnt_q == '0) && (x_q == '0), "request did not start a fresh walk")
	`BCPG_ASSERT_SAME(a_walk_in_range, clk, arst_n, state_q == ST_RUN,
		signed'({1'b0, x_q}) <= y_q, "walk running past the octant boundary")
	`BCPG_ASSERT_SAME(a_count_capped, clk, arst_n, 1'b1,
		cnt_q <= CNT_W'(MAX_RESULTS), "result count beyond the cap")
	`BCPG_ASSERT_NEXT(a_last_ends_walk, clk, arst_n, adv && last_nx,
		(state_q == ST_IDLE) && m_tvalid_q && m_tlast_q, "final result did not end the walk")

endmodule

`default_nettype wire
